[rtl/cdsc_pkg.sv]
// shared types and constants for the chunk deframer with sequence check
package cdsc_pkg;

   localparam int POS_W   = 11;
   localparam int SIZE_W  = 10;
   localparam int SEQ_W   = 10;
   localparam int COUNT_W = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SEQ_W-1:0] SEQ_HALF = SEQ_W'(1 << (SEQ_W - 1));

   typedef enum logic [1:0] {
      KIND_DELIVERED = 2'd0,
      KIND_RESEND    = 2'd1,
      KIND_OVERRUN   = 2'd2
   } result_kind_type;

   // one parsed chunk header or one overrun, handed from parser to checker
   typedef struct packed {
      logic              overrun;
      logic [1:0]        flags;
      logic [SIZE_W-1:0] size;
      logic [POS_W-1:0]  offset;
      logic [SEQ_W-1:0]  seq;
      logic              conn;
   } chunk_event_type;

endpackage

[rtl/chunk_deframer_with_sequence_check_unit.sv]
// top level of the chunk deframer with sequence check
// usage:
//   req_ channel carries the chunk area of a packet one byte per transaction,
//   with packet size, chunk count and connection flag repeated on every byte;
//   req_first_byte restarts the parse for a new packet
//   rsp_ channel gives at most one transaction per byte: a delivered chunk,
//   a resend request or a parse stop on overrun, with the running ack
// throughput: one byte per cycle while req_stall is low; the parser in the
//   front keeps all its state in registers, and the checker in the back pops
//   one queued event per cycle while the output is empty or not stalled
// path: the event of a taken byte is written into the event queue, and the
//   output register loads it from the queue head after earlier events, when
//   the output is empty or not held by rsp_stall
// stall: rsp_stall holds the output register; the back then stops popping
//   and the four-entry event queue absorbs parser events; req_stall rises
//   only while that queue is full
// reset: synchronous; clears the parse state, the ack to zero, the queue
//   and the output valid
module chunk_deframer_with_sequence_check_unit #(
   parameter int PACKET_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic [10:0] req_packet_size,
   input  logic [7:0]  req_chunk_count,
   input  logic        req_has_connection,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [1:0]  rsp_chunk_flags,
   output logic [9:0]  rsp_chunk_size,
   output logic [10:0] rsp_payload_offset,
   output logic [9:0]  rsp_chunk_sequence,
   output logic [9:0]  rsp_current_ack
);
   import cdsc_pkg::*;

   logic            queue_full;
   logic            push;
   chunk_event_type push_event;
   logic            pop;
   logic            head_valid;
   chunk_event_type head_event;

   // stall the byte stream only when the event queue has no room
   assign req_stall = queue_full;

   // front: position tracking, header collection, payload skipping
   cdsc_front #(
      .PACKET_BYTES (PACKET_BYTES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_packet_size    (req_packet_size),
      .req_chunk_count    (req_chunk_count),
      .req_has_connection (req_has_connection),
      .queue_full         (queue_full),
      .push               (push),
      .push_event         (push_event)
   );

   // events in parse order, so the ack seen by each result is in order too
   cdsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .head_valid (head_valid),
      .head_event (head_event),
      .full       (queue_full)
   );

   // back: ack check, drop of old chunks, output register
   cdsc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_event         (head_event),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_chunk_flags    (rsp_chunk_flags),
      .rsp_chunk_size     (rsp_chunk_size),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_chunk_sequence (rsp_chunk_sequence),
      .rsp_current_ack    (rsp_current_ack)
   );

endmodule

[rtl/cdsc_front.sv]
// chunk header parser: tracks position, collects headers, skips payloads
module cdsc_front #(
   parameter int PACKET_BYTES = 2048
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_first_byte,
   input  logic [10:0]              req_packet_size,
   input  logic [7:0]               req_chunk_count,
   input  logic                     req_has_connection,
   input  logic                     queue_full,
   output logic                     push,
   output cdsc_pkg::chunk_event_type push_event
);
   import cdsc_pkg::*;

   localparam int LIMIT = (PACKET_BYTES < (1 << POS_W)) ? PACKET_BYTES : ((1 << POS_W) - 1);
   localparam logic [POS_W-1:0] LIMIT_SIZE = POS_W'(LIMIT);

   logic                active_ff, active_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [COUNT_W-1:0]  taken_ff, taken_in;
   logic [15:0]         hbytes_ff, hbytes_in;
   logic [1:0]          hidx_ff, hidx_in;
   logic [SIZE_W-1:0]   skip_ff, skip_in;

   logic accept;
   assign accept = req_valid && !queue_full;

   always_comb begin
      logic [POS_W-1:0]   psize;
      logic [POS_W-1:0]   pos;
      logic [COUNT_W-1:0] taken;
      logic [15:0]        hb;
      logic [1:0]         hidx;
      logic [SIZE_W-1:0]  skip;
      logic               active;
      logic [1:0]         hflags;
      logic [POS_W:0]     hdr_end;
      logic [POS_W:0]     hend;
      logic [POS_W:0]     chunk_end;
      logic [SIZE_W-1:0]  size;
      logic [SEQ_W-1:0]   seq;
      logic               finish;

      psize  = (req_packet_size > LIMIT_SIZE) ? LIMIT_SIZE : req_packet_size;
      pos    = req_first_byte ? '0 : pos_ff;
      taken  = req_first_byte ? '0 : taken_ff;
      hb     = req_first_byte ? '0 : hbytes_ff;
      hidx   = req_first_byte ? '0 : hidx_ff;
      skip   = req_first_byte ? '0 : skip_ff;
      active = req_first_byte || active_ff;

      active_in = active_ff;
      pos_in    = pos_ff;
      taken_in  = taken_ff;
      hbytes_in = hbytes_ff;
      hidx_in   = hidx_ff;
      skip_in   = skip_ff;
      push      = 1'b0;
      push_event = '0;
      push_event.conn = req_has_connection;

      hflags    = req_data_byte[7:6];
      hdr_end   = {1'b0, pos} + (hflags[0] ? (POS_W+1)'(3) : (POS_W+1)'(2));
      hend      = {1'b0, pos} + (POS_W+1)'(1);
      finish    = 1'b0;
      seq       = '0;
      size      = '0;
      chunk_end = '0;

      if (accept) begin
         active_in = active;
         pos_in    = pos;
         taken_in  = taken;
         hbytes_in = hb;
         hidx_in   = hidx;
         skip_in   = skip;
         if (active) begin
            pos_in = pos + POS_W'(1);
            if (skip != '0) begin
               skip_in = skip - SIZE_W'(1);
            end else if (hidx == 2'd0) begin
               if (taken >= req_chunk_count) begin
                  active_in = 1'b0;
               end else begin
                  taken_in = taken + COUNT_W'(1);
                  if (hdr_end > {1'b0, psize}) begin
                     // header itself runs past the packet
                     active_in        = 1'b0;
                     hidx_in          = 2'd0;
                     push             = 1'b1;
                     push_event.overrun = 1'b1;
                     push_event.flags = hflags;
                  end else begin
                     hbytes_in = {8'h00, req_data_byte};
                     hidx_in   = 2'd1;
                  end
               end
            end else if (hidx == 2'd1) begin
               hbytes_in = {hb[7:0], req_data_byte};
               if (hb[6]) begin
                  hidx_in = 2'd2;
               end else begin
                  finish = 1'b1;
               end
            end else begin
               hbytes_in = hb;
               seq = {hb[7:6], hb[5:4] | req_data_byte[7:6], req_data_byte[5:0]};
               finish = 1'b1;
            end

            if (finish) begin
               hidx_in   = 2'd0;
               size      = {hbytes_in[13:8], hbytes_in[3:0]};
               chunk_end = hend + {2'b00, size};
               push      = 1'b1;
               push_event.flags = hbytes_in[15:14];
               if (chunk_end > {1'b0, psize}) begin
                  active_in          = 1'b0;
                  push_event.overrun = 1'b1;
               end else begin
                  skip_in           = size;
                  push_event.size   = size;
                  push_event.offset = hend[POS_W-1:0];
                  push_event.seq    = seq;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
         taken_ff  <= '0;
         hbytes_ff <= '0;
         hidx_ff   <= '0;
         skip_ff   <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         taken_ff  <= taken_in;
         hbytes_ff <= hbytes_in;
         hidx_ff   <= hidx_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

[rtl/cdsc_queue.sv]
// short event queue between parser and sequence checker
module cdsc_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cdsc_pkg::chunk_event_type push_event,
   input  logic                      pop,
   output logic                      head_valid,
   output cdsc_pkg::chunk_event_type head_event,
   output logic                      full
);
   import cdsc_pkg::*;

   chunk_event_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_event = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/cdsc_back.sv]
// sequence checker with running ack and output register
module cdsc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  cdsc_pkg::chunk_event_type head_event,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_result_kind,
   output logic [1:0]                rsp_chunk_flags,
   output logic [9:0]                rsp_chunk_size,
   output logic [10:0]               rsp_payload_offset,
   output logic [9:0]                rsp_chunk_sequence,
   output logic [9:0]                rsp_current_ack
);
   import cdsc_pkg::*;

   logic [SEQ_W-1:0]  ack_ff, ack_in;
   logic              valid_ff, valid_in;
   result_kind_type   kind_ff, kind_in;
   logic [1:0]        flags_ff, flags_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [POS_W-1:0]  offset_ff, offset_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [SEQ_W-1:0]  rack_ff, rack_in;
   logic              can_load;

   assign can_load = !valid_ff || !rsp_stall;
   assign pop      = can_load && head_valid;

   always_comb begin
      logic [SEQ_W-1:0] next_seq;
      logic             is_old;
      logic             emit;

      next_seq = ack_ff + SEQ_W'(1);
      if (ack_ff < SEQ_HALF) begin
         is_old = (head_event.seq <= ack_ff) || (head_event.seq >= ack_ff + SEQ_HALF);
      end else begin
         is_old = (head_event.seq <= ack_ff) && (head_event.seq >= ack_ff - SEQ_HALF);
      end

      ack_in    = ack_ff;
      emit      = 1'b1;
      kind_in   = KIND_DELIVERED;
      flags_in  = head_event.flags;
      size_in   = head_event.size;
      offset_in = head_event.offset;
      seq_in    = head_event.seq;

      if (head_event.overrun) begin
         kind_in = KIND_OVERRUN;
      end else if (head_event.conn && head_event.flags[0]) begin
         if (head_event.seq == next_seq) begin
            ack_in = next_seq;
         end else if (is_old) begin
            emit = 1'b0;
         end else begin
            kind_in = KIND_RESEND;
         end
      end

      if (!pop) begin
         ack_in = ack_ff;
      end
      rack_in  = ack_in;
      valid_in = can_load ? (pop && emit) : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         ack_ff   <= ack_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= kind_in;
         flags_ff  <= flags_in;
         size_ff   <= size_in;
         offset_ff <= offset_in;
         seq_ff    <= seq_in;
         rack_ff   <= rack_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_chunk_flags    = flags_ff;
   assign rsp_chunk_size     = size_ff;
   assign rsp_payload_offset = offset_ff;
   assign rsp_chunk_sequence = seq_ff;
   assign rsp_current_ack    = rack_ff;

endmodule
